// ----- hw/rtl/stp_pkg.sv -----
// shared constants and types for the subtitle timing line parser
`timescale 1ns / 1ps
package stp_pkg;

    localparam int unsigned MS_W   = 64;
    localparam int unsigned PART_W = 10;

    // characters of the line syntax
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [PART_W-1:0] MAX_MIN_SEC = PART_W'(59);

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_FIRST    = 3'd1,
        ERR_NO_ARROW     = 3'd2,
        ERR_BAD_SECOND   = 3'd3,
        ERR_TRAILING     = 3'd4,
        ERR_END_BEFORE   = 3'd5
    } t_err;

    typedef struct packed {
        logic            valid_res;
        t_err            error_code;
        logic [MS_W-1:0] from_ms;
        logic [MS_W-1:0] end_ms;
    } t_result;

endpackage

// ----- hw/rtl/stp_char_if.sv -----
// character channel: one byte of the timing line per item
`timescale 1ns / 1ps
interface stp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- hw/rtl/stp_res_if.sv -----
// result channel: one parsed timing line per item
`timescale 1ns / 1ps
interface stp_res_if;
    logic                     valid;
    logic                     ready;
    logic                     valid_res;
    logic [2:0]               error_code;
    logic [stp_pkg::MS_W-1:0] from_ms;
    logic [stp_pkg::MS_W-1:0] end_ms;

    modport source (output valid, output valid_res, output error_code,
                    output from_ms, output end_ms, input ready);
    modport sink   (input valid, input valid_res, input error_code,
                    input from_ms, input end_ms, output ready);
endinterface

// ----- hw/rtl/stp_core.sv -----
// line state machine, stamp digit accumulation and end-of-line result
`timescale 1ns / 1ps
module stp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_character,
    input  logic             i_last,
    output stp_pkg::t_result o_result
);

    localparam int unsigned W  = stp_pkg::MS_W;
    localparam int unsigned PW = stp_pkg::PART_W;
    localparam int unsigned XW = W + 10;

    // sub-steps inside one stamp
    localparam logic [3:0] SUB_HOURS  = 4'd0;
    localparam logic [3:0] SUB_MIN_HI = 4'd1;
    localparam logic [3:0] SUB_MIN_LO = 4'd2;
    localparam logic [3:0] SUB_COLON  = 4'd3;
    localparam logic [3:0] SUB_SEC_HI = 4'd4;
    localparam logic [3:0] SUB_SEC_LO = 4'd5;
    localparam logic [3:0] SUB_COMMA  = 4'd6;
    localparam logic [3:0] SUB_MS_0   = 4'd7;
    localparam logic [3:0] SUB_MS_1   = 4'd8;
    localparam logic [3:0] SUB_MS_2   = 4'd9;

    typedef enum logic [3:0] {
        PH_STAMP1, PH_SP1, PH_A2, PH_A3, PH_SP2, PH_STAMP2, PH_AFTER, PH_DONE, PH_ERR
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [3:0]      r_sub, n_sub;
    logic [1:0]      r_dc, n_dc;
    logic [W-1:0]    r_hours, n_hours;
    logic [PW-1:0]   r_part, n_part;
    logic [W-1:0]    r_total, n_total;
    logic [W-1:0]    r_first, n_first;
    stp_pkg::t_err   r_err, n_err;

    // stamp datapath
    logic            s_restart;
    logic [3:0]      s_sub;
    logic [1:0]      s_dc;
    logic [W-1:0]    s_hours;
    logic            is_dig, is_ws;
    logic [3:0]      dig;
    logic [PW-1:0]   part_x10;
    logic [XW-1:0]   wide_h, wide_t;
    logic [XW-1:0]   mul10_h, mul60_h, mul60_t, mul1000_t;
    logic            st_fail, st_done;
    logic [3:0]      st_sub;
    logic [1:0]      st_dc;
    logic [W-1:0]    st_hours, st_total;
    logic [PW-1:0]   st_part;
    stp_pkg::t_err   code;

    assign is_dig = (i_character >= stp_pkg::CH_ZERO) && (i_character <= stp_pkg::CH_NINE);
    assign is_ws  = (i_character == stp_pkg::CH_SPACE) ||
                    ((i_character >= stp_pkg::CH_TAB) && (i_character <= stp_pkg::CH_CR));
    assign dig    = i_character[3:0];

    // first non-space after the arrow starts the second stamp from clean hours
    assign s_restart = (r_phase == PH_SP2);
    assign s_sub     = s_restart ? SUB_HOURS : r_sub;
    assign s_dc      = s_restart ? 2'd0 : r_dc;
    assign s_hours   = s_restart ? '0 : r_hours;

    assign part_x10 = PW'({r_part[PW-4:0], 3'b000}) + PW'({r_part[PW-2:0], 1'b0})
                    + PW'(dig);

    // constant multiply-adds, the upper bits flag a 64-bit overflow
    assign wide_h    = XW'(s_hours);
    assign wide_t    = XW'(r_total);
    assign mul10_h   = (wide_h << 3) + (wide_h << 1) + XW'(dig);
    assign mul60_h   = (wide_h << 6) - (wide_h << 2) + XW'(r_part);
    assign mul60_t   = (wide_t << 6) - (wide_t << 2) + XW'(r_part);
    assign mul1000_t = (wide_t << 10) - (wide_t << 4) - (wide_t << 3) + XW'(part_x10);

    always_comb begin
        st_fail  = 1'b0;
        st_done  = 1'b0;
        st_sub   = s_sub;
        st_dc    = s_dc;
        st_hours = s_hours;
        st_part  = r_part;
        st_total = r_total;
        case (s_sub) inside
            SUB_HOURS: begin
                if (is_dig) begin
                    st_fail  = |mul10_h[XW-1:W];
                    st_hours = mul10_h[W-1:0];
                    st_dc    = (s_dc == 2'd2) ? 2'd2 : s_dc + 2'd1;
                end else if (i_character == stp_pkg::CH_COLON && s_dc == 2'd2) begin
                    st_sub = SUB_MIN_HI;
                end else begin
                    st_fail = 1'b1;
                end
            end
            SUB_MIN_HI, SUB_SEC_HI, SUB_MS_0: begin
                st_fail = !is_dig;
                st_part = PW'(dig);
                st_sub  = s_sub + 4'd1;
            end
            SUB_MIN_LO, SUB_SEC_LO, SUB_MS_1: begin
                st_fail = !is_dig;
                st_part = part_x10;
                st_sub  = s_sub + 4'd1;
            end
            SUB_COLON: begin
                st_fail  = (i_character != stp_pkg::CH_COLON) ||
                           (r_part > stp_pkg::MAX_MIN_SEC) || (|mul60_h[XW-1:W]);
                st_total = mul60_h[W-1:0];
                st_sub   = SUB_SEC_HI;
            end
            SUB_COMMA: begin
                st_fail  = (i_character != stp_pkg::CH_COMMA) ||
                           (r_part > stp_pkg::MAX_MIN_SEC) || (|mul60_t[XW-1:W]);
                st_total = mul60_t[W-1:0];
                st_sub   = SUB_MS_0;
            end
            SUB_MS_2: begin
                st_fail  = !is_dig || (|mul1000_t[XW-1:W]);
                st_part  = part_x10;
                st_total = mul1000_t[W-1:0];
                st_done  = 1'b1;
            end
            default: begin
                st_fail = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        n_dc    = r_dc;
        n_hours = r_hours;
        n_part  = r_part;
        n_total = r_total;
        n_first = r_first;
        n_err   = r_err;
        unique case (r_phase)
            PH_STAMP1: begin
                if (st_fail) begin
                    n_phase = PH_ERR;
                    n_err   = stp_pkg::ERR_BAD_FIRST;
                end else begin
                    n_sub   = st_sub;
                    n_dc    = st_dc;
                    n_hours = st_hours;
                    n_part  = st_part;
                    n_total = st_total;
                    if (st_done) begin
                        n_first = st_total;
                        n_phase = PH_SP1;
                    end
                end
            end
            PH_SP1: begin
                if (i_character == stp_pkg::CH_DASH) begin
                    n_phase = PH_A2;
                end else if (i_character != stp_pkg::CH_SPACE) begin
                    n_phase = PH_ERR;
                    n_err   = stp_pkg::ERR_NO_ARROW;
                end
            end
            PH_A2: begin
                if (i_character == stp_pkg::CH_DASH) begin
                    n_phase = PH_A3;
                end else begin
                    n_phase = PH_ERR;
                    n_err   = stp_pkg::ERR_NO_ARROW;
                end
            end
            PH_A3: begin
                if (i_character == stp_pkg::CH_GT) begin
                    n_phase = PH_SP2;
                end else begin
                    n_phase = PH_ERR;
                    n_err   = stp_pkg::ERR_NO_ARROW;
                end
            end
            PH_SP2, PH_STAMP2: begin
                if (!(s_restart && i_character == stp_pkg::CH_SPACE)) begin
                    if (st_fail) begin
                        n_phase = PH_ERR;
                        n_err   = stp_pkg::ERR_BAD_SECOND;
                    end else begin
                        n_sub   = st_sub;
                        n_dc    = st_dc;
                        n_hours = st_hours;
                        n_part  = st_part;
                        n_total = st_total;
                        n_phase = st_done ? PH_AFTER : PH_STAMP2;
                    end
                end
            end
            PH_AFTER: begin
                if (is_ws) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_ERR;
                    n_err   = stp_pkg::ERR_TRAILING;
                end
            end
            PH_DONE, PH_ERR: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

    // line outcome as it stands after this item
    always_comb begin
        unique case (n_phase)
            PH_ERR:              code = n_err;
            PH_AFTER, PH_DONE:   code = (n_total < n_first) ? stp_pkg::ERR_END_BEFORE
                                                            : stp_pkg::ERR_NONE;
            PH_STAMP1:           code = stp_pkg::ERR_BAD_FIRST;
            PH_SP1, PH_A2, PH_A3: code = stp_pkg::ERR_NO_ARROW;
            default:             code = stp_pkg::ERR_BAD_SECOND;
        endcase
        o_result.valid_res  = (code == stp_pkg::ERR_NONE);
        o_result.error_code = code;
        o_result.from_ms    = (code == stp_pkg::ERR_NONE) ? n_first : '0;
        o_result.end_ms     = (code == stp_pkg::ERR_NONE) ? n_total : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_STAMP1;
            r_sub   <= SUB_HOURS;
            r_dc    <= '0;
            r_hours <= '0;
            r_part  <= '0;
            r_total <= '0;
            r_first <= '0;
            r_err   <= stp_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_dc    <= n_dc;
            r_hours <= n_hours;
            r_part  <= n_part;
            r_total <= n_total;
            r_first <= n_first;
            r_err   <= n_err;
        end
    end

endmodule

// ----- hw/rtl/subtitle_timing_line_parser_top.sv -----
// top level: input register, parser core and result register
//
//  channel    | modport | payload                                   | per item
//  i_char_if  | sink    | character[7:0], last                      | one byte of the line
//  o_res_if   | source  | valid_res, error_code[2:0], from_ms[63:0], end_ms[63:0] | one line
//
// one byte is taken every cycle unless stalled; a last byte is held in the input register,
// its result then in the result register; the rate is set by the state update in the core
// i_rst_n is synchronous and returns the parser to the start of a line
// a waiting result stalls the input only when a further last byte reaches the core
`timescale 1ns / 1ps
module subtitle_timing_line_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stp_char_if.sink    i_char_if,
    stp_res_if.source   o_res_if
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;
    logic             r_out_valid;
    stp_pkg::t_result r_out;
    stp_pkg::t_result core_result;
    logic             out_free;
    logic             step;
    logic             in_take;

    assign out_free = !r_out_valid || o_res_if.ready;
    // a byte that is not last never needs the result register
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign in_take  = !r_in_valid || step;

    assign i_char_if.ready = in_take;

    stp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_character (r_in_char),
        .i_last      (r_in_last),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_char_if.valid;
        end
        if (in_take) begin
            r_in_char <= i_char_if.character;
            r_in_last <= i_char_if.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_valid <= 1'b0;
        end
        if (step && r_in_last) begin
            r_out <= core_result;
        end
    end

    assign o_res_if.valid      = r_out_valid;
    assign o_res_if.valid_res  = r_out.valid_res;
    assign o_res_if.error_code = 3'(r_out.error_code);
    assign o_res_if.from_ms    = r_out.from_ms;
    assign o_res_if.end_ms     = r_out.end_ms;

endmodule
